@@ src/hotp_pkg.sv @@
// ----------------------------------------------------------------------------
// hotp_pkg
// Shared types and constants for the HOTP code generator.
// ----------------------------------------------------------------------------
package hotp_pkg;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0]  IPAD = 8'h36;
	localparam logic [7:0]  OPAD = 8'h5C;
	localparam logic [19:0] CODE_MOD = 20'd1000000;
	localparam logic [31:0] PAD_WORD = 32'h80000000;
	localparam logic [31:0] INNER_BITS = 32'd576;
	localparam logic [31:0] OUTER_BITS = 32'd672;

	// register indexes
	localparam logic [2:0] REG_KEY_LEN = 3'd0;
	localparam logic [2:0] REG_KEY_W0  = 3'd1;
	localparam logic [2:0] REG_KEY_W1  = 3'd2;
	localparam logic [2:0] REG_KEY_W2  = 3'd3;
	localparam logic [2:0] REG_KEY_W3  = 3'd4;

	// control from sequencer to compression core
	typedef struct packed {
		logic        start;   // begin a compression on the loaded block
		logic        init;    // chaining value reset to H0..H4
	} comp_ctrl_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

endpackage

@@ src/hotp_sha1.sv @@
// ----------------------------------------------------------------------------
// hotp_sha1
// SHA-1 compression unit: one round per cycle, message schedule in a
// 16-word circular memory (registered reads, read-modify-write).
// ----------------------------------------------------------------------------
module hotp_sha1 (
	input  logic                clk,
	input  logic                arst_n,
	input  hotp_pkg::comp_ctrl_t ctrl,
	input  logic                blk_we,     // load message word
	input  logic [3:0]          blk_addr,
	input  logic [31:0]         blk_data,
	output logic                done,       // one-cycle pulse
	output logic [159:0]        digest
);
	// schedule memory
	logic [31:0] wmem [16];
	logic [31:0] rd0_q, rd1_q, rd2_q, rd3_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] h_q [5];
	logic [6:0]  rnd_q;
	logic        run_q;
	logic [3:0]  wr_addr, ra0, ra1, ra2, ra3;
	logic [31:0] w_cur, f, k, t;
	logic        wr_en;

	function automatic logic [31:0] rotl32(input logic [31:0] v);
		rotl32 = {v[30:0], v[31]};
	endfunction

	// schedule: round i uses w[i]; w[i]=rotl(w[i-3]^w[i-8]^w[i-14]^w[i-16])
	// reads are issued one round ahead for round rnd_q+1; while idle they
	// point at word 0 so the start edge fetches the round-0 word
	logic [6:0] nxt;
	logic [3:0] ra_base;
	assign nxt = rnd_q + 7'd1;
	assign ra_base = run_q ? nxt[3:0] : 4'd0;
	assign ra0 = ra_base;
	assign ra1 = ra_base + 4'd13;
	assign ra2 = ra_base + 4'd8;
	assign ra3 = ra_base + 4'd2;

	logic [31:0] wsched;
	logic        sched_q;
	assign wsched = rotl32(rd1_q ^ rd2_q ^ rd3_q ^ rd0_q);
	assign w_cur  = sched_q ? wsched : rd0_q;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = hotp_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = hotp_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = hotp_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = hotp_pkg::K3;
		end
		t = hotp_pkg::rotl(a_q, 5) + f + e_q + k + w_cur;
	end

	assign wr_en   = blk_we | (run_q & sched_q);
	assign wr_addr = blk_we ? blk_addr : rnd_q[3:0];

	// memory with registered reads; a write of the current round's word is
	// forwarded into the next read when addresses collide
	always_ff @(posedge clk) begin
		if (wr_en)
			wmem[wr_addr] <= blk_we ? blk_data : wsched;
		rd0_q <= (wr_en && wr_addr == ra0) ? (blk_we ? blk_data : wsched) : wmem[ra0];
		rd1_q <= (wr_en && wr_addr == ra1) ? (blk_we ? blk_data : wsched) : wmem[ra1];
		rd2_q <= (wr_en && wr_addr == ra2) ? (blk_we ? blk_data : wsched) : wmem[ra2];
		rd3_q <= (wr_en && wr_addr == ra3) ? (blk_we ? blk_data : wsched) : wmem[ra3];
	end

	// round control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			rnd_q   <= '0;
			done    <= 1'b0;
			sched_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctrl.start) begin
				run_q   <= 1'b1;
				rnd_q   <= '0;
				sched_q <= 1'b0;
			end else if (run_q) begin
				rnd_q   <= nxt;
				sched_q <= (nxt >= 7'd16);
				if (rnd_q == 7'd79) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// working variables and chaining value; the start edge also reads w[0]
	// into rd0_q for round 0
	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			h_q[0] <= hotp_pkg::H0; h_q[1] <= hotp_pkg::H1; h_q[2] <= hotp_pkg::H2;
			h_q[3] <= hotp_pkg::H3; h_q[4] <= hotp_pkg::H4;
		end
		if (ctrl.start) begin
			a_q <= ctrl.init ? hotp_pkg::H0 : h_q[0];
			b_q <= ctrl.init ? hotp_pkg::H1 : h_q[1];
			c_q <= ctrl.init ? hotp_pkg::H2 : h_q[2];
			d_q <= ctrl.init ? hotp_pkg::H3 : h_q[3];
			e_q <= ctrl.init ? hotp_pkg::H4 : h_q[4];
		end else if (run_q) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= hotp_pkg::rotl(b_q, 30);
			b_q <= a_q;
			a_q <= t;
			if (rnd_q == 7'd79) begin
				h_q[0] <= h_q[0] + t;
				h_q[1] <= h_q[1] + a_q;
				h_q[2] <= h_q[2] + hotp_pkg::rotl(b_q, 30);
				h_q[3] <= h_q[3] + c_q;
				h_q[4] <= h_q[4] + d_q;
			end
		end
	end

	assign digest = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

	// a round counter never runs past the last round
	a_rnd: assert property (@(posedge clk) disable iff (!arst_n) run_q |-> rnd_q <= 7'd79)
		else $error("round counter overran");
	a_done: assert property (@(posedge clk) disable iff (!arst_n) done |-> !run_q)
		else $error("done while running");
	a_load: assert property (@(posedge clk) disable iff (!arst_n) blk_we |-> !run_q)
		else $error("block load during compression");
endmodule

@@ src/hotp_trunc.sv @@
// ----------------------------------------------------------------------------
// hotp_trunc
// Dynamic truncation and reduction modulo one million by reciprocal
// multiplication: operand, quotient and remainder are registered in turn.
// ----------------------------------------------------------------------------
module hotp_trunc (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [159:0] digest,
	output logic         done,
	output logic [19:0]  code
);
	// ceil(2^51 / 1e6); exact quotient for any 31-bit dividend
	localparam logic [31:0] RECIP = 32'd2251799814;

	logic [3:0]  off;
	logic [31:0] sel;
	logic [30:0] val_q;
	logic [11:0] quo_q;
	logic [62:0] prod;
	logic [31:0] qm;
	logic [30:0] diff;
	logic [30:0] rem_q;
	logic        mul_q, sub_q;

	// pick four bytes at the offset in the low nibble of the last byte
	assign off = digest[3:0];
	assign sel = digest[159 - 8*off -: 32];

	// quotient = (val * RECIP) >> 51, remainder = val - quotient * 1e6
	assign prod = 63'(val_q) * 63'(RECIP);
	assign qm   = 32'(quo_q) * 32'(hotp_pkg::CODE_MOD);
	assign diff = val_q - qm[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q <= 1'b0;
			sub_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			mul_q <= go;
			sub_q <= mul_q;
			done  <= sub_q;
		end
	end

	always_ff @(posedge clk) begin
		if (go)
			val_q <= sel[30:0];
		if (mul_q)
			quo_q <= prod[62:51];
		if (sub_q)
			rem_q <= diff;
	end

	assign code = rem_q[19:0];

	a_rng: assert property (@(posedge clk) disable iff (!arst_n) done |-> rem_q < 31'd1000000)
		else $error("remainder out of range");
endmodule

@@ src/hotp_code_generator_core.sv @@
// ----------------------------------------------------------------------------
// hotp_code_generator_core
// HOTP (HMAC-SHA1, six digits) code generator with an APB key port.
//
// channel   direction  signals
// cmd       in         start, busy, counter[63:0]
// result    out        code_valid, code[19:0]
// cfg       in/out     psel penable pwrite paddr pwdata prdata pready
//
// One code runs the single-round SHA-1 unit four times over the schedule memory
// (each pass loads a block, starts and runs the rounds), then the reduction,
// from the transfer to code_valid.
// busy is high from start until code_valid; code_valid lasts one cycle.
// The result side cannot stall; the next transfer is taken once busy drops.
// Reset clears the key registers and control; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hotp_code_generator_core #(
	parameter int KEY_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] counter,
	output logic        code_valid,
	output logic [19:0] code,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	localparam int EFF = (KEY_BYTES < 32) ? KEY_BYTES : 32;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LOAD  = 6'b000010,
		S_KICK  = 6'b000100,
		S_RUN   = 6'b001000,
		S_TRUNC = 6'b010000,
		S_WAIT  = 6'b100000
	} state_t;

	state_t      state_q;
	logic [5:0]  klen_q;
	logic [63:0] kw_q [4];
	logic [63:0] ctr_q;
	logic [1:0]  blk_q;      // 0 ipad, 1 counter, 2 opad, 3 inner digest
	logic [4:0]  ld_q;
	logic [159:0] inner_q;
	logic [5:0]  len;
	logic [2:0]  ridx;
	logic        wr;
	hotp_pkg::comp_ctrl_t ctrl;
	logic        c_done, t_done;
	logic [159:0] digest;
	logic [3:0]  waddr;
	logic [31:0] wdata;

	assign pready = 1'b1;
	assign ridx   = paddr[5:3];
	assign wr     = psel & penable & pwrite;
	assign len    = (klen_q > 6'(EFF)) ? 6'(EFF) : klen_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= '0;
			for (int i = 0; i < 4; i++) kw_q[i] <= '0;
		end else if (wr) begin
			if (ridx == hotp_pkg::REG_KEY_LEN)
				klen_q <= pwdata[5:0];
			else if (ridx inside {[hotp_pkg::REG_KEY_W0 : hotp_pkg::REG_KEY_W3]})
				kw_q[2'(ridx - hotp_pkg::REG_KEY_W0)] <= pwdata;
		end
	end

	always_comb begin
		case (ridx)
			hotp_pkg::REG_KEY_LEN: prdata = {58'd0, klen_q};
			hotp_pkg::REG_KEY_W0:  prdata = kw_q[0];
			hotp_pkg::REG_KEY_W1:  prdata = kw_q[1];
			hotp_pkg::REG_KEY_W2:  prdata = kw_q[2];
			hotp_pkg::REG_KEY_W3:  prdata = kw_q[3];
			default:               prdata = '0;
		endcase
	end

	// block word generation; word 0 is loaded last, just before the start
	assign waddr = (ld_q == 5'd15) ? 4'd0 : 4'(ld_q + 5'd1);
	always_comb begin
		logic [7:0] pad;
		logic [5:0] bi;
		logic [7:0] kb;
		pad = blk_q[1] ? hotp_pkg::OPAD : hotp_pkg::IPAD;
		wdata = '0;
		case (blk_q)
			2'd0, 2'd2: begin
				for (int b = 0; b < 4; b++) begin
					bi = 6'({waddr, 2'(b)});
					kb = (bi < len && bi < 6'd32) ? kw_q[bi[4:3]][63 - 8*bi[2:0] -: 8] : 8'd0;
					wdata[31 - 8*b -: 8] = kb ^ pad;
				end
			end
			2'd1: begin
				case (waddr)
					4'd0:    wdata = ctr_q[63:32];
					4'd1:    wdata = ctr_q[31:0];
					4'd2:    wdata = hotp_pkg::PAD_WORD;
					4'd15:   wdata = hotp_pkg::INNER_BITS;
					default: wdata = '0;
				endcase
			end
			default: begin
				if (waddr < 4'd5)
					wdata = inner_q[159 - 32*waddr -: 32];
				else if (waddr == 4'd5)
					wdata = hotp_pkg::PAD_WORD;
				else if (waddr == 4'd15)
					wdata = hotp_pkg::OUTER_BITS;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			blk_q   <= '0;
			ld_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_LOAD;
					blk_q   <= '0;
					ld_q    <= '0;
				end
				S_LOAD: begin
					ld_q <= ld_q + 5'd1;
					if (ld_q == 5'd15) state_q <= S_KICK;
				end
				S_KICK: state_q <= S_RUN;
				S_RUN: if (c_done) begin
					ld_q <= '0;
					if (blk_q == 2'd3) state_q <= S_TRUNC;
					else begin
						blk_q   <= blk_q + 2'd1;
						state_q <= S_LOAD;
					end
				end
				S_TRUNC: state_q <= S_WAIT;
				S_WAIT:  if (t_done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) ctr_q <= counter;
		if (state_q == S_RUN && c_done && blk_q == 2'd1) inner_q <= digest;
	end

	assign ctrl = '{start: (state_q == S_KICK), init: (state_q == S_KICK) && !blk_q[0]};
	assign busy = (state_q != S_IDLE);

	hotp_sha1 u_sha1 (
		.clk, .arst_n, .ctrl,
		.blk_we(state_q == S_LOAD), .blk_addr(waddr), .blk_data(wdata),
		.done(c_done), .digest
	);

	hotp_trunc u_trunc (
		.clk, .arst_n, .go(state_q == S_TRUNC), .digest,
		.done(t_done), .code
	);

	assign code_valid = t_done;

	a_valid: assert property (@(posedge clk) disable iff (!arst_n) code_valid |-> state_q == S_WAIT)
		else $error("result outside wait state");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> busy)
		else $error("start not taken");
	a_cdone: assert property (@(posedge clk) disable iff (!arst_n) c_done |-> state_q == S_RUN)
		else $error("stray compression done");
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HOTP code generator: counters are sent through
// the start/busy port under several keys loaded over APB, and every code is
// compared with an HMAC-SHA1 dynamic-truncation predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int DRAIN_CYCLES = 450;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] counter;
	logic        code_valid;
	logic [19:0] code;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	// bench copy of the key registers
	logic [5:0]  key_len_q;
	logic [63:0] key_word_q [4];

	logic [63:0] counter_queue [$];
	logic [19:0] code_queue [$];
	bit          gaps_on;
	int          gap_left;
	int          mismatches;
	int          cycles;

	hotp_code_generator_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .counter(counter),
		.code_valid(code_valid), .code(code), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// one SHA-1 compression: 160-bit chaining value, 512-bit block
	function automatic logic [159:0] sha1_block(input logic [159:0] hv, input logic [511:0] blk);
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		a = hv[159:128]; b = hv[127:96]; c = hv[95:64]; d = hv[63:32]; e = hv[31:0];
		for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
		for (int i = 16; i < 80; i++) begin
			t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {t[30:0], t[31]};
		end
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = hotp_pkg::K0;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = hotp_pkg::K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = hotp_pkg::K2;
			end else begin
				f = b ^ c ^ d; k = hotp_pkg::K3;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[i];
			e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
		end
		return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d, hv[31:0] + e};
	endfunction

	// key block XORed with a pad byte; bytes past the key length count as zero
	function automatic logic [511:0] padded_key(input logic [7:0] pad);
		logic [511:0] blk;
		int len;
		len = (key_len_q > 32) ? 32 : key_len_q;
		for (int i = 0; i < 64; i++) begin
			blk[511 - 8*i -: 8] = pad;
			if (i < len) blk[511 - 8*i -: 8] = pad ^ key_word_q[i / 8][63 - 8*(i % 8) -: 8];
		end
		return blk;
	endfunction

	// HMAC-SHA1 of the counter, dynamic truncation, mod one million
	function automatic logic [19:0] hotp_code(input logic [63:0] ctr);
		logic [159:0] inner, outer;
		logic [511:0] blk;
		logic [3:0]   off;
		logic [31:0]  val;
		inner = {hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2, hotp_pkg::H3, hotp_pkg::H4};
		inner = sha1_block(inner, padded_key(hotp_pkg::IPAD));
		blk = '0;
		blk[511:448] = ctr;
		blk[447:416] = hotp_pkg::PAD_WORD;
		blk[31:0] = hotp_pkg::INNER_BITS;
		inner = sha1_block(inner, blk);
		outer = {hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2, hotp_pkg::H3, hotp_pkg::H4};
		outer = sha1_block(outer, padded_key(hotp_pkg::OPAD));
		blk = '0;
		blk[511:352] = inner;
		blk[351:320] = hotp_pkg::PAD_WORD;
		blk[31:0] = hotp_pkg::OUTER_BITS;
		outer = sha1_block(outer, blk);
		off = outer[3:0];
		val = outer[159 - 8*off -: 32];
		val[31] = 1'b0;
		return 20'(val % 32'd1000000);
	endfunction

	// driver: one transfer when start is high and busy is low
	always @(posedge clk or negedge arst_n) begin
		logic        nxt_start;
		logic [63:0] nxt_ctr;
		if (!arst_n) begin
			start <= 1'b0;
			counter <= '0;
			gap_left = 0;
		end else begin
			nxt_start = start;
			nxt_ctr = counter;
			if (start && !busy) begin
				code_queue.push_back(hotp_code(counter));
				nxt_start = 1'b0;
			end
			if (gap_left > 0) begin
				gap_left--;
			end else if (!nxt_start && counter_queue.size() > 0) begin
				if (gaps_on && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(1, 17);
				end else begin
					nxt_start = 1'b1;
					nxt_ctr = counter_queue.pop_front();
				end
			end
			start <= nxt_start;
			counter <= nxt_ctr;
		end
	end

	// monitor: each code strobe is checked against the oldest prediction
	always @(posedge clk) begin
		logic [19:0] want;
		if (arst_n && code_valid) begin
			if (code_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected code %0d", code);
			end else begin
				want = code_queue.pop_front();
				if (code !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("code mismatch: expected %0d, got %0d", want, code);
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout");
			$display("FAIL hotp_code_generator_core");
			$finish;
		end
	end

	task automatic reg_write(input int idx, input logic [63:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 6'(idx * 8); pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == hotp_pkg::REG_KEY_LEN) key_len_q = data[5:0];
		else if (idx <= hotp_pkg::REG_KEY_W3) key_word_q[idx - hotp_pkg::REG_KEY_W0] = data;
	endtask

	task automatic load_key(input logic [5:0] len, input logic [63:0] w0,
			input logic [63:0] w1, input logic [63:0] w2, input logic [63:0] w3);
		reg_write(hotp_pkg::REG_KEY_LEN, 64'(len));
		reg_write(hotp_pkg::REG_KEY_W0, w0);
		reg_write(hotp_pkg::REG_KEY_W1, w1);
		reg_write(hotp_pkg::REG_KEY_W2, w2);
		reg_write(hotp_pkg::REG_KEY_W3, w3);
	endtask

	// sender stalls until every code of the phase is back
	task automatic drain;
		wait (counter_queue.size() == 0);
		@(posedge clk);
		while (start || busy || code_queue.size() > 0) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_counter;
		case ($urandom_range(0, 3))
			0: return 64'($urandom_range(0, 1000));
			1: return {32'hFFFFFFFF, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] rand_word;
		return {$urandom, $urandom};
	endfunction

	initial begin
		logic [5:0] len;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		key_len_q = '0;
		for (int i = 0; i < 4; i++) key_word_q[i] = '0;
		gaps_on = 1'b1;
		mismatches = 0;
		cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty key out of reset, counter extremes
		counter_queue.push_back(64'h0);
		counter_queue.push_back(64'hFFFFFFFFFFFFFFFF);
		counter_queue.push_back(64'h8000000000000000);
		counter_queue.push_back(64'h5555AAAA5555AAAA);
		drain();

		// well-known 20-byte ASCII key, counters 0..9
		load_key(6'd20, 64'h3132333435363738, 64'h3930313233343536,
			64'h3738393000000000, 64'hFFFFFFFFFFFFFFFF);
		for (int i = 0; i < 10; i++) counter_queue.push_back(64'(i));
		drain();

		// full 32-byte key, then lengths past the limit saturate
		load_key(6'd32, '1, '1, '1, '1);
		counter_queue.push_back(64'h0123456789ABCDEF);
		counter_queue.push_back(64'hFEDCBA9876543210);
		drain();
		reg_write(hotp_pkg::REG_KEY_LEN, 64'd63);
		counter_queue.push_back(64'h0123456789ABCDEF);
		drain();
		reg_write(hotp_pkg::REG_KEY_LEN, 64'hFFFFFFFFFFFFFF21);
		counter_queue.push_back(64'h1);
		drain();

		// writes to unused indexes are ignored; short key with junk beyond it
		load_key(6'd8, 64'hA5A5A5A5A5A5A5A5, '1, '1, '1);
		reg_write(5, '1);
		reg_write(7, '1);
		counter_queue.push_back(64'h2);
		counter_queue.push_back(64'hAAAA5555AAAA5555);
		drain();

		// random keys and counters
		for (int p = 0; p < 9; p++) begin
			case ($urandom_range(0, 3))
				0: len = 6'($urandom_range(33, 63));
				1: len = 6'($urandom_range(0, 1) * 32);
				default: len = 6'($urandom_range(0, 32));
			endcase
			load_key(len, rand_word(), rand_word(), rand_word(), rand_word());
			if (p == 8) gaps_on = 1'b0;
			for (int i = 0; i < 115; i++) counter_queue.push_back(rand_counter());
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && code_queue.size() == 0) begin
			$display("PASS hotp_code_generator_core");
		end else begin
			$display("FAIL hotp_code_generator_core");
		end
		$finish;
	end

endmodule
